>>> hw/rtl/qhtp_pkg.sv
// Shared constants, types and helpers for the triangular-probe hash table.
// No dependencies; the files that use it refer to this package by scoped names.

package qhtp_pkg;

  // Default table size (log2 of slot count)
  localparam int TABLE_BITS = 10;

  // Field widths
  localparam int WORD_W   = 32;
  localparam int KEY_W    = 42;
  localparam int VAL_W    = 24;
  localparam int SLOT_W   = 10;
  localparam int COUNT_W  = 11;
  localparam int FBITS_W  = 5;

  // Stream bus widths (data buses padded to whole bytes)
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 3;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_PROBE_BITS = 1'b0;
  localparam logic REG_VALUE_BITS = 1'b1;
  localparam logic [FBITS_W-1:0] PROBE_BITS_RESET = 5'd6;
  localparam logic [FBITS_W-1:0] VALUE_BITS_RESET = 5'd8;

  // Mode codes
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  // Saturation point of the entry counter
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Field layout settings seen by front and back
  typedef struct packed {
    logic [FBITS_W-1:0] probe_bits;
    logic [FBITS_W-1:0] value_bits;
  } cfg_t;

  // Mask covering the low value_bits bits of a word
  function automatic logic [WORD_W-1:0] value_mask(input logic [FBITS_W-1:0] bits);
    value_mask = (WORD_W'(1) << bits) - WORD_W'(1);
  endfunction

endpackage

>>> hw/rtl/qhtp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module qhtp_ram #(
  parameter int WIDTH = 32,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/qhtp_queue.sv
// Two-entry queue between the classifying front and the probing back.
// Depends on nothing but its width parameter.

module qhtp_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign head  = slot_r[rp_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);

  // Advance pointers and occupancy
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store entry payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/qhtp_front.sv
// Front end: accepts input transfers and precomputes the per-item tags.
// Depends on qhtp_pkg.

module qhtp_front #(
  parameter int TABLE_BITS = qhtp_pkg::TABLE_BITS,
  parameter int ITEM_W = 1 + TABLE_BITS + 2 * qhtp_pkg::WORD_W + qhtp_pkg::VAL_W
) (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [qhtp_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  input  qhtp_pkg::cfg_t                 cfg,
  input  logic                           clearing,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [ITEM_W-1:0]              q_data
);

  logic [qhtp_pkg::KEY_W-1:0]  key;
  logic [qhtp_pkg::VAL_W-1:0]  vin;
  logic [qhtp_pkg::WORD_W-1:0] y;
  logic [qhtp_pkg::WORD_W-1:0] ytag;
  logic [qhtp_pkg::WORD_W-1:0] yins;
  logic [5:0]                  ins_shift;
  logic [qhtp_pkg::WORD_W-1:0] vmask;
  logic [qhtp_pkg::VAL_W-1:0]  vmasked;
  logic [TABLE_BITS-1:0]       home;

  assign in_tready = !q_full && !clearing;
  assign q_push    = in_tvalid && in_tready;

  // Split the key and build the stored tag forms
  always_comb begin
    key       = in_tdata[qhtp_pkg::KEY_W-1:0];
    vin       = in_tdata[qhtp_pkg::KEY_W +: qhtp_pkg::VAL_W];
    home      = key[TABLE_BITS-1:0];
    y         = qhtp_pkg::WORD_W'(key >> TABLE_BITS);
    ytag      = y << cfg.probe_bits;
    ins_shift = {1'b0, cfg.value_bits} + {1'b0, cfg.probe_bits};
    yins      = ins_shift[5] ? '0 : (y << ins_shift[4:0]);
    vmask     = qhtp_pkg::value_mask(cfg.value_bits);
    vmasked   = vin & vmask[qhtp_pkg::VAL_W-1:0];
    q_data    = {in_tuser, home, ytag, yins, vmasked};
  end

endmodule

>>> hw/rtl/qhtp_back.sv
// Back end: clears the table after reset, probes it for each queued item,
// updates it and holds the result transfer. Depends on qhtp_pkg, qhtp_ram.

module qhtp_back #(
  parameter int TABLE_BITS = qhtp_pkg::TABLE_BITS,
  parameter int ITEM_W = 1 + TABLE_BITS + 2 * qhtp_pkg::WORD_W + qhtp_pkg::VAL_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  qhtp_pkg::cfg_t                  cfg,
  output logic                            clearing,
  input  logic                            q_empty,
  input  logic [ITEM_W-1:0]               q_head,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [qhtp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [qhtp_pkg::OUT_USER_W-1:0] out_tuser
);

  localparam int PN_W = TABLE_BITS + 2;
  localparam int WW = qhtp_pkg::WORD_W;
  localparam int VW = qhtp_pkg::VAL_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;

  logic [1:0]            st_r, st_nxt;
  logic [TABLE_BITS-1:0] clr_r, clr_nxt;
  logic                  mode_r, mode_nxt;
  logic [TABLE_BITS-1:0] home_r, home_nxt;
  logic [TABLE_BITS-1:0] z_r, z_nxt;
  logic [PN_W-1:0]       pn_r, pn_nxt;
  logic [WW-1:0]         ytag_r, ytag_nxt;
  logic [WW-1:0]         yins_r, yins_nxt;
  logic [VW-1:0]         vm_r, vm_nxt;
  logic [qhtp_pkg::COUNT_W-1:0] count_r, count_nxt;

  logic                  ov_r, ov_nxt;
  logic                  hit_r, hit_nxt;
  logic                  pres_r, pres_nxt;
  logic                  full_r, full_nxt;
  logic [qhtp_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [VW-1:0]         val_r, val_nxt;

  // Queue head fields
  logic                  q_mode;
  logic [TABLE_BITS-1:0] q_home;
  logic [WW-1:0]         q_ytag;
  logic [WW-1:0]         q_yins;
  logic [VW-1:0]         q_vm;

  // Probe datapath
  logic [WW-1:0]         word;
  logic [WW-1:0]         vmask;
  logic [WW-1:0]         tgt;
  logic [WW-1:0]         new_word;
  logic [PN_W-1:0]       pn1;
  logic [TABLE_BITS-1:0] z1;
  logic                  empty;
  logic                  match;
  logic                  limit_hit;
  logic                  start;

  logic                  ram_we;
  logic [TABLE_BITS-1:0] ram_waddr;
  logic [WW-1:0]         ram_wdata;
  logic [TABLE_BITS-1:0] ram_raddr;

  assign {q_mode, q_home, q_ytag, q_yins, q_vm} = q_head;

  qhtp_ram #(
    .WIDTH (WW),
    .ADDR_W(TABLE_BITS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(word)
  );

  assign clearing   = (st_r == ST_CLEAR);
  assign start      = (st_r == ST_IDLE) && !q_empty && (!ov_r || out_tready);
  assign q_pop      = start;
  assign ram_raddr  = (st_r == ST_CHECK) ? z1 : q_home;

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(qhtp_pkg::OUT_DATA_W - qhtp_pkg::COUNT_W - VW
                        - qhtp_pkg::SLOT_W){1'b0}}, count_r, val_r, slot_r};
  assign out_tuser  = {full_r, pres_r, hit_r};

  // Compare the fetched word and form the next probe
  always_comb begin
    vmask     = qhtp_pkg::value_mask(cfg.value_bits);
    empty     = (word == '0);
    tgt       = ytag_r | WW'(pn_r);
    match     = !empty && ((word >> cfg.value_bits) == tgt);
    pn1       = pn_r + PN_W'(1);
    z1        = z_r + pn_r[TABLE_BITS-1:0];
    limit_hit = ((pn1 >> cfg.probe_bits) != '0);
    new_word  = match ? (word | WW'(vm_r))
                      : (yins_r | (WW'(pn_r) << cfg.value_bits) | WW'(vm_r));
  end

  // Sequencer: clear pass, item start, probe loop, result capture
  always_comb begin
    st_nxt    = st_r;
    clr_nxt   = clr_r;
    mode_nxt  = mode_r;
    home_nxt  = home_r;
    z_nxt     = z_r;
    pn_nxt    = pn_r;
    ytag_nxt  = ytag_r;
    yins_nxt  = yins_r;
    vm_nxt    = vm_r;
    count_nxt = count_r;
    ov_nxt    = ov_r;
    hit_nxt   = hit_r;
    pres_nxt  = pres_r;
    full_nxt  = full_r;
    slot_nxt  = slot_r;
    val_nxt   = val_r;
    ram_we    = 1'b0;
    ram_waddr = z_r;
    ram_wdata = new_word;

    // Drop a result once taken
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (st_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + TABLE_BITS'(1);
        if (clr_r == '1) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          mode_nxt = q_mode;
          home_nxt = q_home;
          z_nxt    = q_home;
          pn_nxt   = PN_W'(1);
          ytag_nxt = q_ytag;
          yins_nxt = q_yins;
          vm_nxt   = q_vm;
          st_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (empty || match) begin
          // Stop at the entry or at a free slot
          ram_we   = (mode_r == qhtp_pkg::MODE_INSERT);
          hit_nxt  = match || (mode_r == qhtp_pkg::MODE_INSERT);
          pres_nxt = match;
          full_nxt = 1'b0;
          slot_nxt = hit_nxt ? qhtp_pkg::SLOT_W'(z_r) : '0;
          if (match && mode_r == qhtp_pkg::MODE_LOOKUP) begin
            val_nxt = VW'(word & vmask);
          end else if (hit_nxt) begin
            val_nxt = VW'(new_word & vmask);
          end else begin
            val_nxt = '0;
          end
          if (!match && mode_r == qhtp_pkg::MODE_INSERT && count_r != qhtp_pkg::COUNT_MAX) begin
            count_nxt = count_r + qhtp_pkg::COUNT_W'(1);
          end
          ov_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end else if (z1 == home_r || limit_hit) begin
          // Probe sequence exhausted: table left unchanged
          hit_nxt  = 1'b0;
          pres_nxt = 1'b0;
          full_nxt = 1'b1;
          slot_nxt = '0;
          val_nxt  = '0;
          ov_nxt   = 1'b1;
          st_nxt   = ST_IDLE;
        end else begin
          z_nxt  = z1;
          pn_nxt = pn1;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    home_r <= home_nxt;
    z_r    <= z_nxt;
    pn_r   <= pn_nxt;
    ytag_r <= ytag_nxt;
    yins_r <= yins_nxt;
    vm_r   <= vm_nxt;
    hit_r  <= hit_nxt;
    pres_r <= pres_nxt;
    full_r <= full_nxt;
    slot_r <= slot_nxt;
    val_r  <= val_nxt;
  end

endmodule

>>> hw/rtl/quotient_hash_table_triangular_probe.sv
// Hash table of integer keys and values with triangular probing: APB register file,
// front end, item queue and probing back end. Depends on qhtp_pkg, qhtp_front, qhtp_queue and qhtp_back.

// After reset the block sweeps the 2^TABLE_BITS slot table to empty, one slot
// per cycle; in_tready stays low for that sweep. Each item then leaves the
// two-entry queue and reads its home slot, then probes the single table read
// port slot by slot until it finds its key, a free slot or the end of its
// probe sequence; the next item starts only once this one is resolved. The
// result sits in an output register while the front keeps accepting items
// into the queue until it is full. Probe and value field widths are set over
// the APB port (0x0 and 0x4) and must only change while no item is in flight.

module quotient_hash_table_triangular_probe #(
  parameter int TABLE_BITS = qhtp_pkg::TABLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: key[41:0], value_in[65:42], zero pad [71:66]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [qhtp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,   // mode
  // out_tdata: slot_index[9:0], value_out[33:10], entry_count[44:34], pad [47:45]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [qhtp_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: hit[0], was_present[1], table_full[2]
  output logic [qhtp_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [qhtp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [qhtp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [qhtp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int ITEM_W = 1 + TABLE_BITS + 2 * qhtp_pkg::WORD_W + qhtp_pkg::VAL_W;

  qhtp_pkg::cfg_t cfg_r, cfg_nxt;
  logic           cfg_wr;
  logic           reg_sel;
  logic           clearing;
  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  logic           q_full;
  logic [ITEM_W-1:0] q_data;
  logic [ITEM_W-1:0] q_head;

  // Register file
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        qhtp_pkg::REG_PROBE_BITS: cfg_nxt.probe_bits = cfg_pwdata[qhtp_pkg::FBITS_W-1:0];
        qhtp_pkg::REG_VALUE_BITS: cfg_nxt.value_bits = cfg_pwdata[qhtp_pkg::FBITS_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      qhtp_pkg::REG_PROBE_BITS: cfg_prdata = qhtp_pkg::CFG_DATA_W'(cfg_r.probe_bits);
      qhtp_pkg::REG_VALUE_BITS: cfg_prdata = qhtp_pkg::CFG_DATA_W'(cfg_r.value_bits);
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.probe_bits <= qhtp_pkg::PROBE_BITS_RESET;
      cfg_r.value_bits <= qhtp_pkg::VALUE_BITS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  qhtp_front #(
    .TABLE_BITS(TABLE_BITS),
    .ITEM_W    (ITEM_W)
  ) u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cfg      (cfg_r),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  qhtp_queue #(
    .WIDTH(ITEM_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_data),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  qhtp_back #(
    .TABLE_BITS(TABLE_BITS),
    .ITEM_W    (ITEM_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .clearing  (clearing),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

>>> hw/rtl/qhtp_checker.sv
// Port-level checks on the result stream, bound to the top level.
// Depends on qhtp_pkg and quotient_hash_table_triangular_probe.

module qhtp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [qhtp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [qhtp_pkg::OUT_USER_W-1:0] out_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A miss reports slot and value as zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[33:0] == 34'd0)
    else $error("miss carries slot or value bits");

  // A key already stored is always a hit
  a_present_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("was_present without hit");

  // An exhausted probe never hits
  a_full_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> !out_tuser[0] && !out_tuser[1])
    else $error("table_full together with hit");

endmodule

bind quotient_hash_table_triangular_probe qhtp_checker u_qhtp_checker (.*);
